// File: sv/vfa_pkg.sv
package vfa_pkg;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int PW = 2 * DW;
	localparam int WW = 2 * DW + 2;
	localparam int QW = FB + 1;

	typedef enum logic [2:0] {
		ACT_ADD   = 3'd0,
		ACT_SUB   = 3'd1,
		ACT_SCALE = 3'd2,
		ACT_DOT   = 3'd3,
		ACT_CROSS = 3'd4,
		ACT_MAG   = 3'd5,
		ACT_NORM  = 3'd6,
		ACT_NEG   = 3'd7
	} act_t;

	typedef logic signed [DW-1:0] word_t;

	typedef struct packed {
		act_t       act;
		word_t      rx;
		word_t      ry;
		word_t      rz;
		word_t      sc;
		logic [2:0] neg;
	} side_t;

	localparam word_t WMAX = {1'b0, {(DW-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(DW-1){1'b0}}};

	// Drops the fraction bits of a wide product sum, then saturates.
	function automatic word_t sat_wide(input logic signed [WW-1:0] v);
		logic signed [WW-FB-1:0] t;
		word_t r;
		t = v[WW-1:FB];
		if ((&t[WW-FB-1:DW-1]) || !(|t[WW-FB-1:DW-1])) begin
			r = t[DW-1:0];
		end else begin
			r = t[WW-FB-1] ? WMIN : WMAX;
		end
		return r;
	endfunction

	function automatic word_t sat_narrow(input logic signed [DW:0] v);
		word_t r;
		if (v[DW] == v[DW-1]) begin
			r = v[DW-1:0];
		end else begin
			r = v[DW] ? WMIN : WMAX;
		end
		return r;
	endfunction

endpackage

// File: sv/vfa_norm.sv
module vfa_norm (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic [vfa_pkg::PW-1:0]                  sumsq,
	input  logic [2:0][vfa_pkg::DW-1:0]             mag,
	input  vfa_pkg::side_t                          side_in,
	output logic                                    out_valid,
	output logic [vfa_pkg::DW-1:0]                  root,
	output logic [2:0][vfa_pkg::QW-1:0]             quot,
	output vfa_pkg::side_t                          side_out
);

	localparam int DW = vfa_pkg::DW;
	localparam int PW = vfa_pkg::PW;
	localparam int QW = vfa_pkg::QW;
	localparam int FB = vfa_pkg::FB;

	// Square root: one result bit per stage.
	logic                      sv    [DW+1];
	logic [PW-1:0]             sx    [DW+1];
	logic [DW:0]               srem  [DW+1];
	logic [DW-1:0]             sroot [DW+1];
	logic [2:0][DW-1:0]        smag  [DW+1];
	vfa_pkg::side_t            sside [DW+1];

	assign sv[0]    = in_valid;
	assign sx[0]    = sumsq;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign smag[0]  = mag;
	assign sside[0] = side_in;

	for (genvar k = 0; k < DW; k++) begin : g_sqrt
		logic [DW+2:0] r2;
		logic [DW+2:0] tr;
		logic          ge;
		assign r2 = {srem[k], sx[k][PW-1:PW-2]};
		assign tr = {1'b0, sroot[k], 2'b01};
		assign ge = (r2 >= tr);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv[k+1] <= 1'b0;
			end else if (en) begin
				sv[k+1] <= sv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sx[k+1]    <= {sx[k][PW-3:0], 2'b00};
				srem[k+1]  <= ge ? (DW+1)'(r2 - tr) : r2[DW:0];
				sroot[k+1] <= {sroot[k][DW-2:0], ge};
				smag[k+1]  <= smag[k];
				sside[k+1] <= sside[k];
			end
		end
	end

	// Division of each magnitude, scaled up by the fraction bits, by the root.
	// The root is never below any component magnitude, so the quotient fits QW bits
	// and the first partial remainder is already below the divisor.
	logic                      dv    [QW+1];
	logic [DW-1:0]             dm    [QW+1];
	logic [2:0][DW-1:0]        drem  [QW+1];
	logic [2:0][QW-1:0]        dnq   [QW+1];
	vfa_pkg::side_t            dside [QW+1];

	assign dv[0]    = sv[DW];
	assign dm[0]    = sroot[DW];
	assign dside[0] = sside[DW];
	for (genvar c = 0; c < 3; c++) begin : g_dinit
		assign drem[0][c] = {1'b0, smag[DW][c][DW-1:1]};
		assign dnq[0][c]  = QW'(smag[DW][c][0]) << FB;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [2:0][DW:0] r2;
		logic [2:0]       ge;
		for (genvar c = 0; c < 3; c++) begin : g_lane
			assign r2[c] = {drem[k][c], dnq[k][c][QW-1]};
			assign ge[c] = (r2[c] >= {1'b0, dm[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[k+1] <= 1'b0;
			end else if (en) begin
				dv[k+1] <= dv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dm[k+1]    <= dm[k];
				dside[k+1] <= dside[k];
				for (int c = 0; c < 3; c++) begin
					drem[k+1][c] <= ge[c] ? DW'(r2[c] - {1'b0, dm[k]}) : r2[c][DW-1:0];
					dnq[k+1][c]  <= {dnq[k][c][QW-2:0], ge[c]};
				end
			end
		end
	end

	assign out_valid = dv[QW];
	assign root      = dm[QW];
	assign quot      = dnq[QW];
	assign side_out  = dside[QW];

endmodule

// File: sv/vector3_fixed_point_alu_top.sv
// Channel   Direction  Handshake             Payload
// request   in         req_valid, req_stall  action, a_x..a_z, b_x..b_z, scale_factor
// response  out        rsp_valid, rsp_stall  out_x, out_y, out_z, scalar_out, status
//
// One transaction is accepted per cycle while req_stall is low; each then passes
// through the 32-stage square root and the 17-stage divider before rsp_valid.
// Reset clears only the valid bits of the stages and the response register.
// A stalled response holds the pipeline only when an item reaches its tail;
// bubbles ahead of the tail keep closing and new transactions keep entering.
module vector3_fixed_point_alu_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [2:0]          action,
	input  logic signed [31:0]  a_x,
	input  logic signed [31:0]  a_y,
	input  logic signed [31:0]  a_z,
	input  logic signed [31:0]  b_x,
	input  logic signed [31:0]  b_y,
	input  logic signed [31:0]  b_z,
	input  logic signed [31:0]  scale_factor,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic signed [31:0]  out_x,
	output logic signed [31:0]  out_y,
	output logic signed [31:0]  out_z,
	output logic signed [31:0]  scalar_out,
	output logic                status
);

	localparam int DW = vfa_pkg::DW;
	localparam int PW = vfa_pkg::PW;
	localparam int WW = vfa_pkg::WW;
	localparam int QW = vfa_pkg::QW;

	logic en;
	logic nv;

	// Stage 1: registered request.
	logic                 v_s1;
	vfa_pkg::act_t        act_s1;
	vfa_pkg::word_t       a_s1 [3];
	vfa_pkg::word_t       b_s1 [3];
	vfa_pkg::word_t       sf_s1;

	// Stage 2: products and the plain componentwise results.
	logic                 v_s2;
	vfa_pkg::act_t        act_s2;
	logic signed [PW-1:0] p_s2 [6];
	vfa_pkg::word_t       simp_s2 [3];
	logic [2:0][DW-1:0]   mag_s2;
	logic [2:0]           neg_s2;

	// Stage 3: exact sums.
	logic                 v_s3;
	vfa_pkg::act_t        act_s3;
	logic signed [WW-1:0] w_s3 [3];
	logic signed [WW-1:0] wd_s3;
	vfa_pkg::word_t       simp_s3 [3];
	logic [2:0][DW-1:0]   mag_s3;
	logic [2:0]           neg_s3;

	// Stage 4: truncated and saturated results.
	logic                 v_s4;
	logic [PW-1:0]        sumsq_s4;
	logic [2:0][DW-1:0]   mag_s4;
	vfa_pkg::side_t       side_s4;

	logic                 rsp_valid_q;
	vfa_pkg::word_t       ox_q, oy_q, oz_q, sc_q;
	logic                 st_q;

	assign en        = !rsp_valid_q || !rsp_stall || !nv;
	assign req_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1  <= vfa_pkg::act_t'(action);
			a_s1[0] <= a_x;
			a_s1[1] <= a_y;
			a_s1[2] <= a_z;
			b_s1[0] <= b_x;
			b_s1[1] <= b_y;
			b_s1[2] <= b_z;
			sf_s1   <= scale_factor;
		end
	end

	vfa_pkg::word_t       ma [6];
	vfa_pkg::word_t       mb [6];
	vfa_pkg::word_t       simp [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ma[i]   = a_s1[i];
			mb[i]   = b_s1[i];
			ma[i+3] = a_s1[i];
			mb[i+3] = b_s1[i];
		end
		unique case (act_s1)
			vfa_pkg::ACT_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					ma[i] = sf_s1;
					mb[i] = a_s1[i];
				end
			end
			vfa_pkg::ACT_CROSS: begin
				ma[0] = a_s1[1]; mb[0] = b_s1[2];
				ma[1] = a_s1[2]; mb[1] = b_s1[0];
				ma[2] = a_s1[0]; mb[2] = b_s1[1];
				ma[3] = a_s1[2]; mb[3] = b_s1[1];
				ma[4] = a_s1[0]; mb[4] = b_s1[2];
				ma[5] = a_s1[1]; mb[5] = b_s1[0];
			end
			vfa_pkg::ACT_MAG, vfa_pkg::ACT_NORM: begin
				for (int i = 0; i < 3; i++) begin
					mb[i] = a_s1[i];
				end
			end
			default: begin
			end
		endcase

		for (int i = 0; i < 3; i++) begin
			unique case (act_s1)
				vfa_pkg::ACT_ADD:
					simp[i] = vfa_pkg::sat_narrow({a_s1[i][DW-1], a_s1[i]} +
						{b_s1[i][DW-1], b_s1[i]});
				vfa_pkg::ACT_SUB:
					simp[i] = vfa_pkg::sat_narrow({a_s1[i][DW-1], a_s1[i]} -
						{b_s1[i][DW-1], b_s1[i]});
				vfa_pkg::ACT_NEG:
					simp[i] = vfa_pkg::sat_narrow(-{a_s1[i][DW-1], a_s1[i]});
				default:
					simp[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2 <= act_s1;
			for (int i = 0; i < 6; i++) begin
				p_s2[i] <= PW'(ma[i]) * PW'(mb[i]);
			end
			for (int i = 0; i < 3; i++) begin
				simp_s2[i] <= simp[i];
				mag_s2[i]  <= a_s1[i][DW-1] ? DW'(-a_s1[i]) : DW'(a_s1[i]);
				neg_s2[i]  <= a_s1[i][DW-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s3  <= act_s2;
			wd_s3   <= WW'(p_s2[0]) + WW'(p_s2[1]) + WW'(p_s2[2]);
			for (int i = 0; i < 3; i++) begin
				w_s3[i]    <= (act_s2 == vfa_pkg::ACT_CROSS) ?
					WW'(p_s2[i]) - WW'(p_s2[i+3]) : WW'(p_s2[i]);
				simp_s3[i] <= simp_s2[i];
			end
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
		end
	end

	vfa_pkg::side_t side;

	always_comb begin
		side     = '0;
		side.act = act_s3;
		side.neg = neg_s3;
		unique case (act_s3)
			vfa_pkg::ACT_ADD, vfa_pkg::ACT_SUB, vfa_pkg::ACT_NEG: begin
				side.rx = simp_s3[0];
				side.ry = simp_s3[1];
				side.rz = simp_s3[2];
			end
			vfa_pkg::ACT_SCALE, vfa_pkg::ACT_CROSS: begin
				side.rx = vfa_pkg::sat_wide(w_s3[0]);
				side.ry = vfa_pkg::sat_wide(w_s3[1]);
				side.rz = vfa_pkg::sat_wide(w_s3[2]);
			end
			vfa_pkg::ACT_DOT: begin
				side.sc = vfa_pkg::sat_wide(wd_s3);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// For magnitude and normalize the three products are squares,
			// so their sum is the unsigned sum of squares.
			sumsq_s4 <= wd_s3[PW-1:0];
			mag_s4   <= mag_s3;
			side_s4  <= side;
		end
	end

	logic [DW-1:0]      root;
	logic [2:0][QW-1:0] quot;
	vfa_pkg::side_t     nside;

	vfa_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.sumsq     (sumsq_s4),
		.mag       (mag_s4),
		.side_in   (side_s4),
		.out_valid (nv),
		.root      (root),
		.quot      (quot),
		.side_out  (nside)
	);

	vfa_pkg::word_t fo [3];
	vfa_pkg::word_t fsc;
	logic           fst;

	always_comb begin
		fo[0] = nside.rx;
		fo[1] = nside.ry;
		fo[2] = nside.rz;
		fsc   = nside.sc;
		fst   = 1'b0;
		if (nside.act == vfa_pkg::ACT_MAG) begin
			fsc = root[DW-1] ? vfa_pkg::WMAX : vfa_pkg::word_t'(root);
		end else if (nside.act == vfa_pkg::ACT_NORM) begin
			if (root == '0) begin
				fst = 1'b1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					fo[i] = nside.neg[i] ? -vfa_pkg::word_t'(DW'(quot[i])) :
						vfa_pkg::word_t'(DW'(quot[i]));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!rsp_valid_q || !rsp_stall) begin
			rsp_valid_q <= nv;
		end
	end

	always_ff @(posedge clk) begin
		if (!rsp_valid_q || !rsp_stall) begin
			ox_q <= fo[0];
			oy_q <= fo[1];
			oz_q <= fo[2];
			sc_q <= fsc;
			st_q <= fst;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign out_x      = ox_q;
	assign out_y      = oy_q;
	assign out_z      = oz_q;
	assign scalar_out = sc_q;
	assign status     = st_q;

endmodule

// File: sv/vfa_checker.sv
module vfa_assert (
	input logic               clk,
	input logic               arst_n,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y,
	input logic signed [31:0] out_z,
	input logic signed [31:0] scalar_out,
	input logic               status
);

	// A stalled response transaction keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(out_x) && $stable(out_y) &&
			$stable(out_z) && $stable(scalar_out) && $stable(status))
		else $error("response changed while stalled");

	// The request side is only held back by a stalled response.
	a_req_free: assert property (@(posedge clk) disable iff (!arst_n)
		!(rsp_valid && rsp_stall) |-> !req_stall)
		else $error("request stalled without a stalled response");

	// Normalising a zero vector gives all-zero outputs.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> out_x == 0 && out_y == 0 && out_z == 0 &&
			scalar_out == 0)
		else $error("status set with non-zero outputs");

	// Scalar results come only with a zero vector.
	a_scalar_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && scalar_out != 0 |-> out_x == 0 && out_y == 0 && out_z == 0 &&
			!status)
		else $error("scalar result alongside a vector result");

endmodule

bind vector3_fixed_point_alu_top vfa_assert u_vfa_assert (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.out_x      (out_x),
	.out_y      (out_y),
	.out_z      (out_z),
	.scalar_out (scalar_out),
	.status     (status)
);

// File: bench/vfa_checker.sv
`timescale 1ns / 1ps

module vfa_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] scale_factor,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic signed [31:0] out_x,
	input  logic signed [31:0] out_y,
	input  logic signed [31:0] out_z,
	input  logic signed [31:0] scalar_out,
	input  logic               status,
	output int                 fail_count,
	output int                 pending
);

	typedef struct {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [31:0] sv;
		logic               st;
	} alu_result_t;

	alu_result_t expected_q[$];

	localparam logic signed [127:0] S_MAX = 128'sd2147483647;
	localparam logic signed [127:0] S_MIN = -128'sd2147483648;

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
		if (v > S_MAX) begin
			return S_MAX[31:0];
		end
		if (v < S_MIN) begin
			return S_MIN[31:0];
		end
		return v[31:0];
	endfunction

	// The arithmetic shift rounds towards minus infinity, as the products require.
	function automatic logic signed [31:0] drop_frac(input logic signed [127:0] v);
		return clamp32(v >>> vfa_pkg::FB);
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [65:0] x);
		logic [65:0] lo;
		logic [65:0] hi;
		logic [65:0] mid;
		lo = '0;
		hi = 66'h1_0000_0000;
		while (hi - lo > 66'd1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid <= x) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return lo[63:0];
	endfunction

	function automatic alu_result_t predict_vector_op(input vfa_pkg::act_t op,
			input logic signed [127:0] a[3], input logic signed [127:0] b[3],
			input logic signed [127:0] s);
		alu_result_t r;
		logic signed [31:0] v[3];
		logic [65:0] sq;
		logic [127:0] m;
		logic [127:0] ua;
		logic [127:0] q;
		v = '{default: '0};
		r.sv = '0;
		r.st = 1'b0;
		case (op)
			vfa_pkg::ACT_ADD: for (int i = 0; i < 3; i++) v[i] = clamp32(a[i] + b[i]);
			vfa_pkg::ACT_SUB: for (int i = 0; i < 3; i++) v[i] = clamp32(a[i] - b[i]);
			vfa_pkg::ACT_SCALE: for (int i = 0; i < 3; i++) v[i] = drop_frac(s * a[i]);
			vfa_pkg::ACT_DOT: r.sv = drop_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
			vfa_pkg::ACT_CROSS: begin
				v[0] = drop_frac(a[1] * b[2] - a[2] * b[1]);
				v[1] = drop_frac(a[2] * b[0] - a[0] * b[2]);
				v[2] = drop_frac(a[0] * b[1] - a[1] * b[0]);
			end
			vfa_pkg::ACT_MAG, vfa_pkg::ACT_NORM: begin
				sq = 66'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
				m = 128'(floor_sqrt(sq));
				if (op == vfa_pkg::ACT_MAG) begin
					r.sv = clamp32(m);
				end else if (m == 0) begin
					r.st = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						ua = (a[i] < 0) ? -a[i] : a[i];
						q = (ua << vfa_pkg::FB) / m;
						v[i] = clamp32((a[i] < 0) ? -$signed(q) : $signed(q));
					end
				end
			end
			default: for (int i = 0; i < 3; i++) v[i] = clamp32(-a[i]);
		endcase
		r.vx = v[0];
		r.vy = v[1];
		r.vz = v[2];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk) begin
		logic signed [127:0] av[3];
		logic signed [127:0] bv[3];
		alu_result_t e;
		if (arst_n && req_valid && !req_stall) begin
			av = '{128'(a_x), 128'(a_y), 128'(a_z)};
			bv = '{128'(b_x), 128'(b_y), 128'(b_z)};
			expected_q.push_back(predict_vector_op(vfa_pkg::act_t'(action), av, bv,
				128'(scale_factor)));
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected transaction", out_x, '0);
			end else begin
				e = expected_q.pop_front();
				if (out_x !== e.vx) report_mismatch("out_x", out_x, e.vx);
				if (out_y !== e.vy) report_mismatch("out_y", out_y, e.vy);
				if (out_z !== e.vz) report_mismatch("out_z", out_z, e.vz);
				if (scalar_out !== e.sv) report_mismatch("scalar_out", scalar_out, e.sv);
				if (status !== e.st) report_mismatch("status", 32'(status), 32'(e.st));
			end
		end
		pending = expected_q.size();
	end
endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [2:0]         action;
	logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scale_factor;
	logic               rsp_valid;
	logic               rsp_stall;
	logic signed [31:0] out_x, out_y, out_z, scalar_out;
	logic               status;
	int                 fail_count;
	int                 pending;
	int                 cycle_count;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	bit                 hold_off;

	localparam int CYCLE_LIMIT = 200000;

	vector3_fixed_point_alu_top DUT (.*);

	vfa_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver side: random stalls, or a long hold-off while the request side fills up.
	always @(negedge clk) begin
		if (hold_off) begin
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return $signed($urandom_range(0, 'h3ffff)) - 32'sh20000;
			4: return 32'sh00010000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input vfa_pkg::act_t op, input logic signed [31:0] ax,
			input logic signed [31:0] ay, input logic signed [31:0] az,
			input logic signed [31:0] bx, input logic signed [31:0] by,
			input logic signed [31:0] bz, input logic signed [31:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		action <= op;
		a_x <= ax; a_y <= ay; a_z <= az;
		b_x <= bx; b_y <= by; b_z <= bz;
		scale_factor <= s;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		send_item(vfa_pkg::act_t'($urandom_range(7)), pick_word(), pick_word(),
			pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
	endtask

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		req_valid = 1'b0;
		action = vfa_pkg::ACT_ADD;
		{a_x, a_y, a_z, b_x, b_y, b_z, scale_factor} = '0;
		rsp_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int k = 0; k < 8; k++) begin
			send_item(vfa_pkg::act_t'(k), 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
				32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
			send_item(vfa_pkg::act_t'(k), 32'sh80000000, 32'sh80000000, 32'sh80000000,
				32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
		end
		// Zero vector for normalize and magnitude, and a small vector whose root is truncated.
		send_item(vfa_pkg::ACT_NORM, 0, 0, 0, 5, 6, 7, 9);
		send_item(vfa_pkg::ACT_MAG, 0, 0, 0, 0, 0, 0, 0);
		send_item(vfa_pkg::ACT_NORM, 1, 0, -1, 0, 0, 0, 0);
		send_item(vfa_pkg::ACT_NORM, 32'sh00030000, 32'sh00040000, 0, 0, 0, 0, 0);
		send_item(vfa_pkg::ACT_SCALE, -1, 1, 32'sh00018000, 0, 0, 0, 32'sh00008000);
		send_item(vfa_pkg::ACT_NEG, 32'sh80000000, 1, -1, 0, 0, 0, 0);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 48 : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? 48 : 0;
			if (ph == 3) send_idle_pct = 8;
			if (ph == 3) recv_stall_pct = 8;
			for (int n = 0; n < 460; n++) begin
				if (ph == 1 && n == 100) begin
					fork
						begin
							hold_off = 1'b1;
							repeat (300) @(negedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
				send_random();
			end
		end
		req_valid <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// File: files.f
sv/vfa_pkg.sv
sv/vfa_norm.sv
sv/vector3_fixed_point_alu_top.sv
sv/vfa_checker.sv
bench/vfa_checker.sv
bench/tb.sv
